[hw/rtl/i2cms_pkg.sv]
// shared types, codes and constants of the i2c master transfer sequencer
package i2cms_pkg;

  // default transfer buffer depth
  localparam int BUFFER_DEPTH_DEF = 256;

  // action codes
  localparam logic [2:0] ACT_LOAD        = 3'd0;
  localparam logic [2:0] ACT_READ        = 3'd1;
  localparam logic [2:0] ACT_START_WRITE = 3'd2;
  localparam logic [2:0] ACT_START_READ  = 3'd3;
  localparam logic [2:0] ACT_BUS_EVENT   = 3'd4;

  // engine status codes, prescaler bits masked
  localparam logic [7:0] BC_BUS_ERROR   = 8'h00;
  localparam logic [7:0] BC_START       = 8'h08;
  localparam logic [7:0] BC_REP_START   = 8'h10;
  localparam logic [7:0] BC_MT_SLA_ACK  = 8'h18;
  localparam logic [7:0] BC_MT_SLA_NACK = 8'h20;
  localparam logic [7:0] BC_MT_DATA_ACK = 8'h28;
  localparam logic [7:0] BC_MT_DATA_NACK = 8'h30;
  localparam logic [7:0] BC_ARB_LOST    = 8'h38;
  localparam logic [7:0] BC_MR_SLA_ACK  = 8'h40;
  localparam logic [7:0] BC_MR_SLA_NACK = 8'h48;
  localparam logic [7:0] BC_MR_DATA_ACK = 8'h50;
  localparam logic [7:0] BC_MR_DATA_NACK = 8'h58;

  // bus commands
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_SEND  = 3'd2;
  localparam logic [2:0] CMD_STEP  = 3'd3;
  localparam logic [2:0] CMD_STOP  = 3'd4;

  // transfer status
  localparam logic [2:0] ST_COMPLETE = 3'd0;
  localparam logic [2:0] ST_WORKING  = 3'd1;
  localparam logic [2:0] ST_NOSLAVE  = 3'd2;
  localparam logic [2:0] ST_DATANACK = 3'd3;
  localparam logic [2:0] ST_ARBLOST  = 3'd4;
  localparam logic [2:0] ST_BUSERR   = 3'd5;

  // input item
  typedef struct packed {
    logic [2:0] action;
    logic [6:0] slave_addr;
    logic [7:0] byte_count;
    logic       no_stop;
    logic [7:0] buf_index;
    logic [7:0] buf_data;
    logic [7:0] bus_code;
    logic [7:0] rx_byte;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] tx_data;
    logic       tx_valid;
    logic [2:0] bus_command;
    logic       ack_enable;
    logic [2:0] status;
    logic       busy_res;
    logic [7:0] read_data;
    logic       done_pulse;
  } out_item_t;

  // buffer access controls from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // result fields settled at accept, buffer data joins them in the merge stage
  typedef struct packed {
    logic       tx_from_mem;
    logic [7:0] tx_const;
    logic       tx_valid;
    logic [2:0] bus_command;
    logic       ack_enable;
    logic [2:0] status;
    logic       rd_from_mem;
    logic       done_pulse;
  } pend_t;

endpackage

[hw/rtl/i2c_master_transfer_sequencer.sv]
// i2c master transfer sequencer top level
//
// Use: each input transfer carries one action: load or read a transfer
// buffer byte, start a write or read transfer, or present an engine status
// code (bus event) with the received byte. Every accepted input transfer
// produces exactly one result transfer that tells the engine what to load,
// which bus command to issue, the ack enable and the transfer status.
// Pipeline: an accepted item is registered in the merge stage, which waits
// for the buffer ram read data, then the output register holds the result.
// Throughput: one item per cycle while out_ready is high. Transfer state
// updates at accept and the buffer ram is a single port accessed at most
// once per item at accept, so a following item always sees what the
// previous one wrote.
// Reset (rst_n low, synchronous): status complete, counters and flags zero,
// pipeline empty. Buffer contents are undefined until written.
// Stall: when out_ready is low the output register and merge stage hold,
// and in_ready drops once both are full; nothing is dropped or repeated.
module i2c_master_transfer_sequencer #(
  parameter int BUFFER_DEPTH = i2cms_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2cms_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2cms_pkg::out_item_t  out_item
);
  import i2cms_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic          in_fire;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;
  pend_t         pend;

  assign in_fire = in_valid && in_ready;

  // sequencer
  i2cms_ctrl #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_item   (in_item),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .pend      (pend)
  );

  // transfer buffer
  i2cms_buf_mem #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_buf_mem (
    .clk       (clk),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  // result pipeline
  i2cms_result_pipe u_result_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .pend      (pend),
    .mem_rdata (mem_rdata),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

[hw/rtl/i2cms_buf_mem.sv]
// transfer buffer: single port synchronous ram with registered read data
module i2cms_buf_mem #(
  parameter int BUFFER_DEPTH = i2cms_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                            clk,
  input  i2cms_pkg::mem_ctl_t             mem_ctl,
  input  logic [$clog2(BUFFER_DEPTH)-1:0] mem_addr,
  input  logic [7:0]                      mem_wdata,
  output logic [7:0]                      mem_rdata
);
  import i2cms_pkg::*;

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rdata_r <= mem[mem_addr];
    end
  end

  assign mem_rdata = rdata_r;

endmodule

[hw/rtl/i2cms_ctrl.sv]
// transfer sequencer: decodes actions and bus events, keeps transfer state
module i2cms_ctrl #(
  parameter int BUFFER_DEPTH = i2cms_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_fire,
  input  i2cms_pkg::in_item_t             in_item,
  output i2cms_pkg::mem_ctl_t             mem_ctl,
  output logic [$clog2(BUFFER_DEPTH)-1:0] mem_addr,
  output logic [7:0]                      mem_wdata,
  output i2cms_pkg::pend_t                pend
);
  import i2cms_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic [AW-1:0] PTR_LAST = AW'(BUFFER_DEPTH - 1);
  localparam logic [8:0]    DEPTH9   = 9'(BUFFER_DEPTH);

  logic [7:0]    addr_byte_r, addr_byte_nxt;
  logic [7:0]    remaining_r, remaining_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          sup_stop_r, sup_stop_nxt;
  logic [2:0]    status_r, status_nxt;
  logic          ack_r, ack_nxt;

  logic          idx_ok;
  logic [AW-1:0] ptr_inc;
  logic [7:0]    rem_dec;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_byte_r <= '0;
      remaining_r <= '0;
      ptr_r       <= '0;
      sup_stop_r  <= 1'b0;
      status_r    <= ST_COMPLETE;
      ack_r       <= 1'b0;
    end else if (in_fire) begin
      addr_byte_r <= addr_byte_nxt;
      remaining_r <= remaining_nxt;
      ptr_r       <= ptr_nxt;
      sup_stop_r  <= sup_stop_nxt;
      status_r    <= status_nxt;
      ack_r       <= ack_nxt;
    end
  end

  assign idx_ok  = ({1'b0, in_item.buf_index} < DEPTH9);
  assign ptr_inc = (ptr_r == PTR_LAST) ? '0 : ptr_r + AW'(1);
  assign rem_dec = (remaining_r != 8'd0) ? remaining_r - 8'd1 : 8'd0;

  // next state, buffer access and result fields
  always_comb begin
    addr_byte_nxt = addr_byte_r;
    remaining_nxt = remaining_r;
    ptr_nxt       = ptr_r;
    sup_stop_nxt  = sup_stop_r;
    status_nxt    = status_r;
    ack_nxt       = ack_r;

    mem_ctl.rd_en = 1'b0;
    mem_ctl.wr_en = 1'b0;
    mem_addr      = ptr_r;
    mem_wdata     = in_item.rx_byte;

    pend.tx_from_mem = 1'b0;
    pend.tx_const    = 8'd0;
    pend.tx_valid    = 1'b0;
    pend.bus_command = CMD_NONE;
    pend.rd_from_mem = 1'b0;
    pend.done_pulse  = 1'b0;

    case (in_item.action)
      ACT_LOAD: begin
        mem_addr      = in_item.buf_index[AW-1:0];
        mem_wdata     = in_item.buf_data;
        mem_ctl.wr_en = in_fire && idx_ok;
      end
      ACT_READ: begin
        mem_addr         = in_item.buf_index[AW-1:0];
        mem_ctl.rd_en    = in_fire && idx_ok;
        pend.rd_from_mem = idx_ok;
      end
      ACT_START_WRITE, ACT_START_READ: begin
        addr_byte_nxt = {in_item.slave_addr, (in_item.action == ACT_START_READ)};
        remaining_nxt = in_item.byte_count;
        ptr_nxt       = '0;
        status_nxt    = ST_WORKING;
        if (in_item.action == ACT_START_WRITE) begin
          sup_stop_nxt = in_item.no_stop;
        end
        pend.bus_command = CMD_START;
      end
      ACT_BUS_EVENT: begin
        case (in_item.bus_code)
          BC_START, BC_REP_START: begin
            pend.tx_const    = addr_byte_r;
            pend.tx_valid    = 1'b1;
            pend.bus_command = CMD_SEND;
          end
          BC_MT_SLA_ACK, BC_MT_DATA_ACK: begin
            if (remaining_r == 8'd0) begin
              status_nxt       = ST_COMPLETE;
              pend.bus_command = sup_stop_r ? CMD_NONE : CMD_STOP;
              pend.done_pulse  = 1'b1;
            end else begin
              // next payload byte comes from the buffer
              mem_ctl.rd_en    = in_fire;
              pend.tx_from_mem = 1'b1;
              pend.tx_valid    = 1'b1;
              ptr_nxt          = ptr_inc;
              remaining_nxt    = remaining_r - 8'd1;
              pend.bus_command = CMD_STEP;
            end
          end
          BC_MT_SLA_NACK, BC_MR_SLA_NACK: begin
            status_nxt       = ST_NOSLAVE;
            pend.bus_command = CMD_STOP;
          end
          BC_MT_DATA_NACK: begin
            status_nxt       = ST_DATANACK;
            pend.bus_command = CMD_STOP;
          end
          BC_ARB_LOST: begin
            status_nxt       = ST_ARBLOST;
            pend.bus_command = CMD_STEP;
          end
          BC_MR_SLA_ACK: begin
            if (remaining_r == 8'd0) begin
              status_nxt       = ST_COMPLETE;
              pend.bus_command = CMD_STOP;
            end else begin
              ack_nxt          = (remaining_r != 8'd1);
              pend.bus_command = CMD_STEP;
            end
          end
          BC_MR_DATA_ACK, BC_MR_DATA_NACK: begin
            // store received byte at the pointer
            mem_ctl.wr_en = in_fire;
            ptr_nxt       = ptr_inc;
            remaining_nxt = rem_dec;
            if (rem_dec == 8'd1) begin
              ack_nxt = 1'b0;
            end
            if (rem_dec == 8'd0) begin
              status_nxt       = ST_COMPLETE;
              pend.bus_command = CMD_STOP;
              pend.done_pulse  = 1'b1;
            end else begin
              pend.bus_command = CMD_STEP;
            end
          end
          BC_BUS_ERROR: begin
            status_nxt       = ST_BUSERR;
            pend.bus_command = CMD_STOP;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    pend.ack_enable = ack_nxt;
    pend.status     = status_nxt;
  end

endmodule

[hw/rtl/i2cms_result_pipe.sv]
// result path: merge stage for buffer read data and output register
module i2cms_result_pipe (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_fire,
  input  i2cms_pkg::pend_t       pend,
  input  logic [7:0]             mem_rdata,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output i2cms_pkg::out_item_t   out_item
);
  import i2cms_pkg::*;

  logic      s1_v_r;
  pend_t     s1_r;
  logic      out_v_r;
  out_item_t out_r;
  out_item_t merged;
  logic      s1_move;

  assign s1_move  = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || !out_v_r || out_ready;

  // combine settled fields with the buffer read data
  always_comb begin
    merged.tx_data     = s1_r.tx_from_mem ? mem_rdata : s1_r.tx_const;
    merged.tx_valid    = s1_r.tx_valid;
    merged.bus_command = s1_r.bus_command;
    merged.ack_enable  = s1_r.ack_enable;
    merged.status      = s1_r.status;
    merged.busy_res    = (s1_r.status == ST_WORKING);
    merged.read_data   = s1_r.rd_from_mem ? mem_rdata : 8'd0;
    merged.done_pulse  = s1_r.done_pulse;
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= pend;
    end
    if (s1_move) begin
      out_r <= merged;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

endmodule
